// ===== rtl/bsmv_pkg.sv =====
// Shared types, widths and defaults for the block-sparse matrix-vector unit.
`default_nettype none

package bsmv_pkg;

    localparam int DEF_GROUP_SIZE = 4;
    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_MAX_ROWS   = 1024;

    localparam int IDX_W  = 10;
    localparam int VAL_W  = 16;
    localparam int GRP_W  = 8;
    localparam int WGT_W  = 16;
    localparam int SUM_W  = 48;
    localparam int CFG_W  = 11;
    localparam int PROD_W = VAL_W + WGT_W;
    localparam int CHK_W  = 14;

    localparam logic [CFG_W-1:0] N_ROWS_RESET = CFG_W'(1024);
    localparam logic [CFG_W-1:0] N_COLS_RESET = CFG_W'(1024);

    typedef enum logic {
        CFG_N_ROWS = 1'b0,
        CFG_N_COLS = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic                    kind;
        logic [IDX_W-1:0]        x_index;
        logic signed [VAL_W-1:0] x_value;
        logic                    row_end;
        logic [GRP_W-1:0]        group_index;
        logic signed [WGT_W-1:0] weight_0;
        logic signed [WGT_W-1:0] weight_1;
        logic signed [WGT_W-1:0] weight_2;
        logic signed [WGT_W-1:0] weight_3;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        row_index;
        logic signed [SUM_W-1:0] row_sum;
        logic                    last_row;
        logic                    range_error;
    } result_t;

    // Per-entry control that travels alongside the lane data
    typedef struct packed {
        logic valid;
        logic row_end;
        logic skip;
    } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/bsmv_lane.sv =====
// One multiply lane: a bank of the vector store and a registered multiplier.
`default_nettype none

module bsmv_lane #(
    parameter int BANK_DEPTH = 256,
    parameter int BA_W       = 8
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [BA_W-1:0]                  wr_addr,
    input  wire logic [bsmv_pkg::VAL_W-1:0]       wr_data,
    input  wire logic                             rd_en,
    input  wire logic [BA_W-1:0]                  rd_addr,
    input  wire logic signed [bsmv_pkg::WGT_W-1:0] weight,
    output logic signed [bsmv_pkg::PROD_W-1:0]    product
);
    import bsmv_pkg::*;

    logic [VAL_W-1:0]        mem [BANK_DEPTH];
    logic signed [VAL_W-1:0] x_reg;
    logic signed [WGT_W-1:0] w_reg;
    logic signed [PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            x_reg <= mem[rd_addr];
            w_reg <= weight;
        end
        product_reg <= x_reg * w_reg;
    end

    assign product = product_reg;

endmodule

`default_nettype wire

// ===== rtl/bsmv_merge.sv =====
// Merge stage: sums the lane products into the row accumulator and emits rows.
`default_nettype none

module bsmv_merge #(
    parameter int GROUP_SIZE = bsmv_pkg::DEF_GROUP_SIZE,
    parameter int MAX_ROWS   = bsmv_pkg::DEF_MAX_ROWS,
    parameter int RC_W       = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bsmv_pkg::ctl_t                    ctl,
    input  wire logic signed [bsmv_pkg::PROD_W-1:0] product [GROUP_SIZE],
    input  wire logic [bsmv_pkg::CFG_W-1:0]        n_rows,
    output logic                                   done,
    output bsmv_pkg::result_t                      result
);
    import bsmv_pkg::*;

    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] acc_next;
    logic                    err_reg;
    logic [RC_W-1:0]         row_cnt_reg;
    logic                    done_reg;
    result_t                 result_reg;

    logic [CHK_W-1:0] rows;
    logic [CHK_W-1:0] cur_row;
    logic [CHK_W-1:0] row_inc;
    logic             last;

    always_comb
    begin
        acc_next = acc_reg;
        for (int i = 0; i < GROUP_SIZE; i++)
        begin
            acc_next = acc_next + SUM_W'(product[i]);
        end
    end

    // Clamp rows in use to 1..MAX_ROWS; restart the counter if it sits past them
    always_comb
    begin
        if (n_rows == '0)
        begin
            rows = CHK_W'(1);
        end
        else if (CHK_W'(n_rows) > CHK_W'(MAX_ROWS))
        begin
            rows = CHK_W'(MAX_ROWS);
        end
        else
        begin
            rows = CHK_W'(n_rows);
        end
        cur_row = (CHK_W'(row_cnt_reg) >= rows) ? '0 : CHK_W'(row_cnt_reg);
        last    = (cur_row == rows - CHK_W'(1));
        row_inc = cur_row + CHK_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            err_reg     <= 1'b0;
            row_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.valid)
            begin
                if (ctl.row_end)
                begin
                    done_reg    <= 1'b1;
                    acc_reg     <= '0;
                    err_reg     <= 1'b0;
                    row_cnt_reg <= last ? '0 : row_inc[RC_W-1:0];
                end
                else if (ctl.skip)
                begin
                    err_reg <= 1'b1;
                end
                else
                begin
                    acc_reg <= acc_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid && ctl.row_end)
        begin
            result_reg.row_index   <= cur_row[IDX_W-1:0];
            result_reg.row_sum     <= acc_reg;
            result_reg.last_row    <= last;
            result_reg.range_error <= err_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/block_sparse_matvec.sv =====
// Top level of the block-sparse matrix-vector unit: decode, lanes and merge.
// Pipeline: a row-end entry's control passes ctl1_reg and ctl2_reg (bank read, lane
//   multiply), then the merge registers raise done and load result together.
// Throughput: one entry of any kind per cycle; busy stays low, start is taken
//   every cycle. Load writes land in time for a group entry on the next cycle.
// Reset: rst_n clears the accumulator, row counter, error flag and pipeline
//   valids and sets n_rows and n_cols to 1024; the vector banks are not cleared.
// The receiver cannot stall: each result is on result for the one cycle of done.
`default_nettype none

module block_sparse_matvec #(
    parameter int GROUP_SIZE = bsmv_pkg::DEF_GROUP_SIZE,
    parameter int MAX_COLS   = bsmv_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = bsmv_pkg::DEF_MAX_ROWS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire bsmv_pkg::item_t             item,
    output logic                             done,
    output bsmv_pkg::result_t                result,
    input  wire logic                        cfg_we,
    input  wire bsmv_pkg::cfg_idx_t          cfg_index,
    input  wire logic [bsmv_pkg::CFG_W-1:0]  cfg_data
);
    import bsmv_pkg::*;

    // Column c lives in bank c mod GROUP_SIZE at address c / GROUP_SIZE, so a
    // group's columns sit at the same address (the group number) in every bank.
    localparam int BANK_DEPTH = (MAX_COLS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int LANE_W     = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
    localparam int RC_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // Divide the load index by GROUP_SIZE with a reciprocal multiply; the extra
    // three shift bits make it exact over the whole index range for sizes to 8.
    localparam int DIV_SH = IDX_W + 3;
    localparam int RCP_W  = DIV_SH + 1;
    localparam int RECIP  = ((1 << DIV_SH) + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int QP_W   = IDX_W + RCP_W;

    logic [CFG_W-1:0] n_rows_reg;
    logic [CFG_W-1:0] n_cols_reg;

    ctl_t ctl1_reg;
    ctl_t ctl2_reg;
    ctl_t ctl0;

    logic             accept;
    logic             load_ok;
    logic             grp_entry;
    logic             skip;
    logic [CHK_W-1:0] cols;
    logic [CHK_W-1:0] start_col;
    logic [QP_W-1:0]  quot_prod;
    logic [QP_W-1:0]  quot;
    logic [CHK_W-1:0] rem;
    logic [CHK_W-1:0] grp_ext;

    logic signed [PROD_W-1:0] product [GROUP_SIZE];

    // The unit never stalls its source
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Register writes; the user must issue them only while the unit is idle, not enforced here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_rows_reg <= N_ROWS_RESET;
            n_cols_reg <= N_COLS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_N_ROWS: n_rows_reg <= cfg_data;
                CFG_N_COLS: n_cols_reg <= cfg_data;
                default:    n_rows_reg <= n_rows_reg;
            endcase
        end
    end

    // Decode the accepted entry: load address split, group range check
    always_comb
    begin
        load_ok   = accept && !item.kind && (CHK_W'(item.x_index) < CHK_W'(MAX_COLS));
        grp_entry = accept && item.kind && !item.row_end;

        cols      = (CHK_W'(n_cols_reg) > CHK_W'(MAX_COLS)) ? CHK_W'(MAX_COLS)
                                                            : CHK_W'(n_cols_reg);
        start_col = CHK_W'(item.group_index) * CHK_W'(GROUP_SIZE);
        skip      = (start_col + CHK_W'(GROUP_SIZE)) > cols;
        grp_ext   = CHK_W'(item.group_index);

        quot_prod = QP_W'(item.x_index) * QP_W'(RECIP);
        quot      = quot_prod >> DIV_SH;
        rem       = CHK_W'(item.x_index) - CHK_W'(quot) * CHK_W'(GROUP_SIZE);

        ctl0.valid   = accept && item.kind;
        ctl0.row_end = item.row_end;
        ctl0.skip    = skip;
    end

    // Advance entry control alongside the bank read and the multiply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl0;
            ctl2_reg <= ctl1_reg;
        end
    end

    // One lane per column of a group; lanes past the fourth get weight zero
    for (genvar i = 0; i < GROUP_SIZE; i++)
    begin : g_lane
        logic signed [WGT_W-1:0] lane_weight;

        if (i == 0)
        begin : g_w0
            assign lane_weight = item.weight_0;
        end
        else if (i == 1)
        begin : g_w1
            assign lane_weight = item.weight_1;
        end
        else if (i == 2)
        begin : g_w2
            assign lane_weight = item.weight_2;
        end
        else if (i == 3)
        begin : g_w3
            assign lane_weight = item.weight_3;
        end
        else
        begin : g_wz
            assign lane_weight = '0;
        end

        bsmv_lane #(
            .BANK_DEPTH (BANK_DEPTH),
            .BA_W       (BA_W)
        ) u_lane (
            .clk     (clk),
            .wr_en   (load_ok && (rem[LANE_W-1:0] == LANE_W'(i))),
            .wr_addr (quot[BA_W-1:0]),
            .wr_data (item.x_value),
            .rd_en   (grp_entry && !skip),
            .rd_addr (grp_ext[BA_W-1:0]),
            .weight  (lane_weight),
            .product (product[i])
        );
    end

    // Combine the lane products, keep the row sum and emit finished rows
    bsmv_merge #(
        .GROUP_SIZE (GROUP_SIZE),
        .MAX_ROWS   (MAX_ROWS),
        .RC_W       (RC_W)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl2_reg),
        .product (product),
        .n_rows  (n_rows_reg),
        .done    (done),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== bench/tb_block_sparse_matvec.sv =====
// Self-checking testbench for the block-sparse matrix-vector unit.
`timescale 1ns / 1ps

module tb_block_sparse_matvec;
    import bsmv_pkg::*;

    localparam int GROUP        = 4;
    localparam int STORE_DEPTH  = 1024;
    localparam int ROW_LIMIT    = 1024;
    localparam int SETTLE_CYC   = 5;      // lets the result pipeline drain
    localparam int RANDOM_ITEMS = 1950;
    localparam int QUIET_LIMIT  = 2000;   // cycles with no transfer before giving up

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    item_t             entry     = '0;
    logic              done;
    result_t           row_out;
    logic              cfg_we    = 1'b0;
    cfg_idx_t          cfg_index = CFG_N_ROWS;
    logic [CFG_W-1:0]  cfg_data  = '0;

    block_sparse_matvec i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (entry),
        .done      (done),
        .result    (row_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: vector store, running row sum, row counter, sticky
    // range flag and its own copy of both registers.
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] x_mem [0:STORE_DEPTH-1];
    logic [SUM_W-1:0]        acc_sum   = '0;
    int                      row_ctr   = 0;
    logic                    range_err = 1'b0;
    logic [CFG_W-1:0]        rows_reg  = N_ROWS_RESET;
    logic [CFG_W-1:0]        cols_reg  = N_COLS_RESET;

    result_t row_sums_due [$];
    int      mismatches = 0;
    int      quiet_cycles = 0;

    // Stimulus side bookkeeping: which store entries hold data, and the
    // columns in use, so that no group ever reads an unwritten entry.
    bit      loaded [0:STORE_DEPTH-1];
    int      gen_cols  = STORE_DEPTH;
    int      items_sent = 0;
    bit      idle_on   = 1'b1;

    // Work out what one accepted entry does to the row state.
    task automatic predict_entry(input item_t e);
        int      rows;
        int      cols;
        int      first;
        logic    last;
        longint  dot;
        result_t r;
        if (!e.kind) begin
            x_mem[e.x_index] = e.x_value;
        end
        else if (e.row_end) begin
            // Clamp the rows in use to 1..ROW_LIMIT; a shrunk count restarts the counter.
            rows = int'(rows_reg);
            if (rows < 1) rows = 1;
            if (rows > ROW_LIMIT) rows = ROW_LIMIT;
            if (row_ctr >= rows) row_ctr = 0;
            last = (row_ctr == rows - 1);
            r.row_index   = row_ctr[IDX_W-1:0];
            r.row_sum     = acc_sum;
            r.last_row    = last;
            r.range_error = range_err;
            row_sums_due.push_back(r);
            acc_sum   = '0;
            range_err = 1'b0;
            row_ctr   = last ? 0 : row_ctr + 1;
        end
        else begin
            cols = int'(cols_reg);
            if (cols > STORE_DEPTH) cols = STORE_DEPTH;
            first = int'(e.group_index) * GROUP;
            if (first + GROUP > cols) begin
                range_err = 1'b1;
            end
            else begin
                dot = longint'($signed(e.weight_0)) * longint'(x_mem[first])
                    + longint'($signed(e.weight_1)) * longint'(x_mem[first + 1])
                    + longint'($signed(e.weight_2)) * longint'(x_mem[first + 2])
                    + longint'($signed(e.weight_3)) * longint'(x_mem[first + 3]);
                // Wrap modulo 2^48, as the hardware accumulator does.
                acc_sum = acc_sum + dot[SUM_W-1:0];
            end
        end
    endtask

    // Sample at the rising edge: track register writes and accepted entries,
    // then compare any result strobe against the oldest pending row sum.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n) begin
            if (cfg_we) begin
                if (cfg_index == CFG_N_ROWS)
                    rows_reg = cfg_data;
                else
                    cols_reg = cfg_data;
            end
            if (start && !busy)
                predict_entry(entry);
            if (done) begin
                if (row_sums_due.size() == 0) begin
                    $display("%0t: unexpected row result: row %0d sum %0d last %0b err %0b",
                             $time, row_out.row_index, $signed(row_out.row_sum),
                             row_out.last_row, row_out.range_error);
                    mismatches++;
                end
                else begin
                    want = row_sums_due.pop_front();
                    if (row_out.row_index   !== want.row_index   ||
                        row_out.row_sum     !== want.row_sum     ||
                        row_out.last_row    !== want.last_row    ||
                        row_out.range_error !== want.range_error) begin
                        $display("%0t: row result mismatch: expected row %0d sum %0d ",
                                 $time, want.row_index, $signed(want.row_sum),
                                 "last %0b err %0b, ",
                                 want.last_row, want.range_error,
                                 "actual row %0d sum %0d last %0b err %0b",
                                 row_out.row_index, $signed(row_out.row_sum),
                                 row_out.last_row, row_out.range_error);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Stop the run when no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog expired, %0d row results pending",
                     $time, row_sums_due.size());
            $display("tb_block_sparse_matvec: done, errors");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Entry builders: start from random bits so ignored fields toggle too.
    // ------------------------------------------------------------------
    function automatic item_t rand_entry();
        logic [127:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom()};
        return raw[$bits(item_t)-1:0];
    endfunction

    function automatic item_t load_entry(input int idx, input logic [VAL_W-1:0] val);
        item_t e;
        e = rand_entry();
        e.kind    = 1'b0;
        e.x_index = idx[IDX_W-1:0];
        e.x_value = val;
        return e;
    endfunction

    function automatic item_t group_entry(input int g, input logic [WGT_W-1:0] w0,
                                          input logic [WGT_W-1:0] w1,
                                          input logic [WGT_W-1:0] w2,
                                          input logic [WGT_W-1:0] w3);
        item_t e;
        e = rand_entry();
        e.kind        = 1'b1;
        e.row_end     = 1'b0;
        e.group_index = g[GRP_W-1:0];
        e.weight_0    = w0;
        e.weight_1    = w1;
        e.weight_2    = w2;
        e.weight_3    = w3;
        return e;
    endfunction

    function automatic item_t end_entry();
        item_t e;
        e = rand_entry();
        e.kind    = 1'b1;
        e.row_end = 1'b1;
        return e;
    endfunction

    // Offer one entry and hold it until the transfer; insert random idle
    // cycles ahead of it while idling is on.
    task automatic send_entry(input item_t e);
        if (idle_on && $urandom_range(99) < 32) begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 32);
        end
        start <= 1'b1;
        entry <= e;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (!e.kind)
            loaded[e.x_index] = 1'b1;
    endtask

    // Send a group, first loading any of its columns not yet written if it lies within the columns in use.
    task automatic send_group(input int g, input logic [WGT_W-1:0] w0,
                              input logic [WGT_W-1:0] w1, input logic [WGT_W-1:0] w2,
                              input logic [WGT_W-1:0] w3);
        int c;
        if (g * GROUP + GROUP <= gen_cols) begin
            for (c = g * GROUP; c < g * GROUP + GROUP; c++)
                if (!loaded[c])
                    send_entry(load_entry(c, 16'($urandom())));
        end
        send_entry(group_entry(g, w0, w1, w2, w3));
    endtask

    // Drop start and hold off until every pending row result has arrived.
    // Wait on the clock first so the predictor has logged the last transfer.
    task automatic wait_results();
        start <= 1'b0;
        @(posedge clk);
        while (row_sums_due.size() != 0)
            @(posedge clk);
    endtask

    // Drain, then let the pipeline empty behind group entries too.
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Write both registers back to back; only call with the block idle.
    task automatic set_config(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_N_ROWS;
        cfg_data  <= rows;
        @(posedge clk);
        cfg_index <= CFG_N_COLS;
        cfg_data  <= cols;
        @(posedge clk);
        cfg_we    <= 1'b0;
        gen_cols = (int'(cols) > STORE_DEPTH) ? STORE_DEPTH : int'(cols);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Load the extreme values at both ends of the store.
    task automatic test_load_extremes();
        send_entry(load_entry(0, 16'sh7fff));
        send_entry(load_entry(1, 16'sh8000));
        send_entry(load_entry(2, 16'shffff));
        send_entry(load_entry(3, 16'sh0001));
        send_entry(load_entry(1020, 16'sh8000));
        send_entry(load_entry(1021, 16'sh8000));
        send_entry(load_entry(1022, 16'sh8000));
        send_entry(load_entry(STORE_DEPTH - 1, 16'sh8000));
    endtask

    // Full-scale weights on the first and last groups, then an empty row.
    task automatic test_group_extremes();
        send_group(0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        send_group(255, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_entry(end_entry());
        send_entry(end_entry());
        wait_results();
    endtask

    // Groups past the columns in use raise the sticky flag until row end.
    task automatic test_range_error();
        settle();
        set_config(11'd1024, 11'd4);
        send_group(0, 16'sh4000, 16'shc000, 16'sh7fff, 16'sh8000);
        send_group(1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_entry(end_entry());
        settle();
        set_config(11'd1024, 11'd0);
        send_group(0, 16'sh1234, 16'sh5678, 16'sh9abc, 16'shdef0);
        send_entry(end_entry());
        settle();
        // Out-of-range count clamps to the full store.
        set_config(11'd1024, 11'd2047);
        send_group(255, 16'sh7fff, 16'sh0001, 16'shffff, 16'sh8000);
        send_entry(end_entry());
    endtask

    // Row counter: restart when the count shrinks, wrap, and clamp both ways.
    task automatic test_row_wrap();
        settle();
        set_config(11'd2, 11'd1024);
        repeat (3) send_entry(end_entry());
        settle();
        set_config(11'd0, 11'd1024);
        repeat (2) send_entry(end_entry());
        settle();
        set_config(11'd2047, 11'd1024);
        send_entry(end_entry());
    endtask

    // Phases of well-formed rows with random content under random settings,
    // mixed with stray loads and groups that may run past the columns.
    task automatic test_random_rows();
        int phase;
        int row;
        int n;
        int k;
        int pick;
        int target;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        phase  = 0;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            settle();
            case ($urandom_range(7))
                0:       rows = 11'd0;
                1:       rows = 11'd1;
                2:       rows = 11'd1024;
                3:       rows = 11'd2047;
                4:       rows = 11'($urandom_range(2047));
                default: rows = 11'($urandom_range(1, 24));
            endcase
            case ($urandom_range(7))
                0:       cols = 11'd0;
                1:       cols = 11'd4;
                2:       cols = 11'd1024;
                3:       cols = 11'd2047;
                4:       cols = 11'($urandom_range(2047));
                5:       cols = 11'($urandom_range(4, 64));
                default: cols = 11'($urandom_range(4, 1024));
            endcase
            set_config(rows, cols);
            // The third phase inserts no random idle cycles ahead of its entries.
            idle_on = (phase != 2);
            for (row = $urandom_range(8, 30); row > 0 && items_sent < target; row--) begin
                for (n = $urandom_range(6); n > 0; n--) begin
                    pick = $urandom_range(99);
                    if (pick < 8)
                        send_entry(load_entry($urandom_range(STORE_DEPTH - 1),
                                              16'($urandom())));
                    else if (pick < 16 || gen_cols < GROUP)
                        k = $urandom_range(255);
                    else
                        k = $urandom_range(gen_cols / GROUP - 1);
                    if (pick >= 8)
                        send_group(k, 16'($urandom()), 16'($urandom()),
                                   16'($urandom()), 16'($urandom()));
                end
                send_entry(end_entry());
                if ($urandom_range(99) < 6)
                    wait_results();
            end
            phase++;
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_load_extremes();
        test_group_extremes();
        test_range_error();
        test_row_wrap();
        test_random_rows();
        settle();
        if (mismatches == 0 && row_sums_due.size() == 0)
            $display("tb_block_sparse_matvec: done, clean");
        else
            $display("tb_block_sparse_matvec: done, errors");
        $finish;
    end

endmodule
